// ===== hw/rtl/bde_pkg.sv =====
// bde_pkg: opcodes, status codes and cell control types for the deque engine
// depends on nothing; used by bde_cell and bounded_deque_engine
`default_nettype none

package bde_pkg;

  localparam int DATA_W = 32;

  // input opcodes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_APPEND,
    CELL_DROP_BACK,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  head_data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_deque_engine.sv =====
// bounded_deque_engine: bounded double-ended queue built as a chain of cells
// depends on bde_pkg and bde_cell
//
// Usage: raise start with opcode and value; the command transfers at a clock
// edge where start is high and busy is low. Push front, push back, pop back
// and pop front each give one result in the cycle after the transfer, marked
// by strobe, with last set; such commands may be issued every cycle. Dump of
// a queue with N elements holds busy high and emits N results, front to
// back, one per cycle, each registered from the head cell in the dump state;
// the chain rotates by one cell per cycle and is back in order when it ends.
// Dump of an empty queue behaves like a single-result command. Opcodes five
// to seven give no result. Results are on the ports for exactly one cycle;
// the receiver cannot stall. A synchronous reset empties the queue (valid
// bits and the element count clear); no clearing pass over cells is needed.
`default_nettype none

module bounded_deque_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [2:0]                         opcode,
  input  wire logic signed [bde_pkg::DATA_W-1:0]  value,
  output logic                                    strobe,
  output logic signed [bde_pkg::DATA_W-1:0]       data,
  output logic [1:0]                              status,
  output logic                                    last
);
  import bde_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            dump_left;
  logic                     accept;
  logic                     empty;
  logic                     full;
  cell_ctrl_t               ctrl;
  logic [DEPTH-1:0]         cell_valid;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] back_data;
  logic                     strobe_next;
  logic signed [DATA_W-1:0] data_next;
  logic [1:0]               status_next;
  logic                     last_next;

  assign accept = start & ~busy;
  assign busy   = (state == S_DUMP);
  assign empty  = (count == '0);
  assign full   = (count == CW'(DEPTH));

  // chain of element cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     lv;
    logic                     rv;
    logic signed [DATA_W-1:0] ld;
    logic signed [DATA_W-1:0] rd;
    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = value;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rd = cell_data[i];
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    bde_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[i]),
      .data        (cell_data[i])
    );
  end

  // back element: and-or select over the tail marks
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && (i == DEPTH - 1 || !cell_valid[(i + 1) % DEPTH])) begin
        back_data = back_data | cell_data[i];
      end
    end
  end

  // command decode into the broadcast cell control and next count
  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.value     = value;
    ctrl.head_data = cell_data[0];
    count_next     = count;
    if (state == S_DUMP) begin
      ctrl.op = CELL_ROTATE;
    end else if (accept) begin
      unique case (opcode)
        OP_PUSH_FRONT: if (!full) begin
          ctrl.op    = CELL_SHIFT_R;
          count_next = count + CW'(1);
        end
        OP_PUSH_BACK: if (!full) begin
          ctrl.op    = CELL_APPEND;
          count_next = count + CW'(1);
        end
        OP_POP_BACK: if (!empty) begin
          ctrl.op    = CELL_DROP_BACK;
          count_next = count - CW'(1);
        end
        OP_POP_FRONT: if (!empty) begin
          ctrl.op    = CELL_SHIFT_L;
          count_next = count - CW'(1);
        end
        default: ctrl.op = CELL_HOLD;
      endcase
    end
  end

  // next result from the dump sequencer or the accepted command
  always_comb begin
    strobe_next = 1'b0;
    data_next   = '0;
    status_next = ST_OK;
    last_next   = 1'b1;
    if (state == S_DUMP) begin
      strobe_next = 1'b1;
      data_next   = cell_data[0];
      last_next   = (dump_left == CW'(1));
    end else if (accept) begin
      unique case (opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          strobe_next = 1'b1;
          status_next = full ? ST_FULL : ST_OK;
        end
        OP_POP_BACK: begin
          strobe_next = 1'b1;
          if (empty) status_next = ST_EMPTY;
          else data_next = back_data;
        end
        OP_POP_FRONT: begin
          strobe_next = 1'b1;
          if (empty) status_next = ST_EMPTY;
          else data_next = cell_data[0];
        end
        OP_DUMP: begin
          if (empty) begin
            strobe_next = 1'b1;
            status_next = ST_EMPTY;
          end
        end
        default: strobe_next = 1'b0;
      endcase
    end
  end

  // sequencer state, count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_left <= '0;
      strobe    <= 1'b0;
    end else begin
      count  <= count_next;
      strobe <= strobe_next;
      data   <= data_next;
      status <= status_next;
      last   <= last_next;
      unique case (state)
        S_IDLE: begin
          if (accept && opcode == OP_DUMP && !empty) begin
            state     <= S_DUMP;
            dump_left <= count;
          end
        end
        S_DUMP: begin
          dump_left <= dump_left - CW'(1);
          if (dump_left == CW'(1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // occupancy stays a contiguous run from the head cell
  a_thermo: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("cell valid bits not contiguous");

  // element count agrees with the cell valid bits
  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("element count out of step with cells");

  // each dump cycle transfers a result the cycle after
  a_dump_out: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("dump cycle produced no result");

  // a dump never reports a full queue
  a_dump_status: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> (status == ST_OK))
    else $error("bad status during dump");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bde_cell.sv =====
// bde_cell: one slot of the deque chain, holding an element and its valid bit
// depends on bde_pkg; instantiated in a row by bounded_deque_engine
`default_nettype none

module bde_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bde_pkg::cell_ctrl_t                ctrl,
  input  wire logic                               left_valid,
  input  wire logic signed [bde_pkg::DATA_W-1:0]  left_data,
  input  wire logic                               right_valid,
  input  wire logic signed [bde_pkg::DATA_W-1:0]  right_data,
  output logic                                    valid,
  output logic signed [bde_pkg::DATA_W-1:0]       data
);
  import bde_pkg::*;

  logic is_tail;

  // this cell holds the back element
  assign is_tail = valid & ~right_valid;

  // occupancy, kept as a thermometer along the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        CELL_SHIFT_R:   valid <= left_valid;
        CELL_SHIFT_L:   valid <= right_valid;
        CELL_APPEND:    if (!valid && left_valid) valid <= 1'b1;
        CELL_DROP_BACK: if (is_tail) valid <= 1'b0;
        CELL_HOLD, CELL_ROTATE: valid <= valid;
        default:        valid <= valid;
      endcase
    end
  end

  // element moves between neighbors, or loads the pushed value or the head data
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_SHIFT_R: data <= left_data;
      CELL_SHIFT_L: data <= right_data;
      CELL_APPEND:  if (!valid && left_valid) data <= ctrl.value;
      CELL_ROTATE:  data <= is_tail ? ctrl.head_data : right_data;
      CELL_HOLD, CELL_DROP_BACK: data <= data;
      default:      data <= data;
    endcase
  end

endmodule

`default_nettype wire
